/* rtl/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, result kinds and constants for the track parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int DEFAULT_MAX_DELTA_BYTES = 4;

    localparam int DATA_W   = 8;
    localparam int DELTA_W  = 28;
    localparam int TEMPO_W  = 24;
    localparam int KIND_W   = 3;
    localparam int OUT_TDATA_W = 104;

    // 60 s in microseconds over 120 bpm
    localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'((60 * 1000000) / 120);

    localparam logic [KIND_W-1:0] KIND_DELTA   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHANNEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SYSTEM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_META    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_SYSEX_END = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_SYSTEM    = 4'hF;

    localparam logic [7:0] META_PREFIX  = 8'h20;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;

    typedef struct packed {
        logic        track_start;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         status_value;
        logic [6:0]         first_data;
        logic [6:0]         second_data;
        logic [DELTA_W-1:0] delta_ticks;
        logic [7:0]         meta_type;
        logic [7:0]         meta_size;
        logic [TEMPO_W-1:0] tempo_now;
        logic [7:0]         prefix_channel;
        logic               track_done;
    } result_t;

endpackage

/* rtl/mtep_in_reg.sv */
// ----------------------------------------------------------------------------
// MIDI track parser input register
// Captures one byte transfer; frees up as the parse stage consumes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mtep_pkg::in_item_t item_in,
    input  logic              advance,
    output logic              vld,
    output mtep_pkg::in_item_t item
);
    import mtep_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;
    logic     take;
    logic     drain;

    assign drain    = vld_reg && advance;
    assign s_tready = !vld_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (drain)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

/* rtl/mtep_core.sv */
// ----------------------------------------------------------------------------
// MIDI track parser core
// Phase machine and parse state; decides one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module mtep_core #(
    parameter int MAX_DELTA_BYTES = mtep_pkg::DEFAULT_MAX_DELTA_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  mtep_pkg::in_item_t item,
    output logic               emit,
    output mtep_pkg::result_t  res
);
    import mtep_pkg::*;

    localparam int CNT_W = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DELTA_BYTES - 1);

    localparam logic [3:0] PH_DELTA  = 4'd0;
    localparam logic [3:0] PH_STATUS = 4'd1;
    localparam logic [3:0] PH_DATA1  = 4'd2;
    localparam logic [3:0] PH_DATA2  = 4'd3;
    localparam logic [3:0] PH_SYSEX  = 4'd4;
    localparam logic [3:0] PH_SKIP   = 4'd5;
    localparam logic [3:0] PH_MTYPE  = 4'd6;
    localparam logic [3:0] PH_MLEN   = 4'd7;
    localparam logic [3:0] PH_MDATA  = 4'd8;

    logic [3:0]         phase_reg,   phase_next;
    logic [7:0]         rs_reg,      rs_next;
    logic [DELTA_W-1:0] acc_reg,     acc_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [7:0]         first_reg,   first_next;
    logic [7:0]         mtype_reg,   mtype_next;
    logic [7:0]         left_reg,    left_next;
    logic [7:0]         index_reg,   index_next;
    logic [TEMPO_W-1:0] tempo_reg,   tempo_next;
    logic [7:0]         prefix_reg,  prefix_next;
    logic               ended_reg,   ended_next;

    logic [3:0]         ph_eff;
    logic [7:0]         rs_eff;
    logic [DELTA_W-1:0] acc_eff;
    logic [CNT_W-1:0]   cnt_eff;
    logic               end_eff;
    logic [7:0]         b;
    logic [6:0]         b7;
    logic [DELTA_W-1:0] acc_shift;
    logic [7:0]         left_dec;
    logic [7:0]         index_inc;
    logic [7:0]         st_eff;
    logic               emit_c;
    result_t            res_c;

    assign b         = item.data_byte;
    assign b7        = item.data_byte[6:0];
    assign left_dec  = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        // a restart clears the track-local state before this byte is parsed
        ph_eff  = item.track_start ? PH_DELTA : phase_reg;
        rs_eff  = item.track_start ? 8'd0 : rs_reg;
        acc_eff = item.track_start ? '0 : acc_reg;
        cnt_eff = item.track_start ? '0 : cnt_reg;
        end_eff = item.track_start ? 1'b0 : ended_reg;
        acc_shift = {acc_eff[DELTA_W-8:0], b7};

        phase_next  = ph_eff;
        rs_next     = rs_eff;
        acc_next    = acc_eff;
        cnt_next    = cnt_eff;
        first_next  = first_reg;
        mtype_next  = mtype_reg;
        left_next   = left_reg;
        index_next  = index_reg;
        tempo_next  = tempo_reg;
        prefix_next = prefix_reg;
        ended_next  = end_eff;
        st_eff      = rs_eff;

        emit_c = 1'b0;
        res_c  = '0;

        if (!end_eff)
        begin
            unique case (ph_eff)
                PH_STATUS, PH_DATA1:
                begin
                    if (ph_eff == PH_STATUS && b[7])
                    begin
                        if (b[7:4] != HI_SYSTEM)
                        begin
                            rs_next    = b;
                            phase_next = PH_DATA1;
                        end
                        else
                        begin
                            rs_next = 8'd0;
                            if (b == ST_SYSEX)
                            begin
                                phase_next = PH_SYSEX;
                            end
                            else if (b == ST_SONG_POS || b == ST_SONG_SEL)
                            begin
                                first_next = b;
                                left_next  = (b == ST_SONG_POS) ? 8'd2 : 8'd1;
                                phase_next = PH_SKIP;
                            end
                            else if (b == ST_META)
                            begin
                                phase_next = PH_MTYPE;
                            end
                            else
                            begin
                                phase_next         = PH_DELTA;
                                emit_c             = 1'b1;
                                res_c.kind         = KIND_SYSTEM;
                                res_c.status_value = b;
                            end
                        end
                    end
                    else if (ph_eff == PH_STATUS && rs_eff == 8'd0)
                    begin
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_ERROR;
                        res_c.status_value = b;
                    end
                    else
                    begin
                        first_next = {1'b0, b7};
                        if (rs_eff[7:4] == HI_PROGRAM || rs_eff[7:4] == HI_PRESSURE)
                        begin
                            phase_next         = PH_DELTA;
                            emit_c             = 1'b1;
                            res_c.kind         = KIND_CHANNEL;
                            res_c.status_value = rs_eff;
                            res_c.first_data   = b7;
                        end
                        else
                        begin
                            phase_next = PH_DATA2;
                        end
                    end
                end
                PH_DATA2:
                begin
                    // note-on at zero velocity reads as note-off
                    if (rs_eff[7:4] == HI_NOTE_ON && b7 == 7'd0)
                    begin
                        st_eff = {HI_NOTE_OFF, rs_eff[3:0]};
                    end
                    phase_next         = PH_DELTA;
                    emit_c             = 1'b1;
                    res_c.kind         = KIND_CHANNEL;
                    res_c.status_value = st_eff;
                    res_c.first_data   = first_reg[6:0];
                    res_c.second_data  = b7;
                end
                PH_SYSEX:
                begin
                    if (b == ST_SYSEX_END)
                    begin
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_SYSTEM;
                        res_c.status_value = ST_SYSEX;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_SYSTEM;
                        res_c.status_value = first_reg;
                    end
                end
                PH_MTYPE:
                begin
                    mtype_next = b;
                    phase_next = PH_MLEN;
                end
                PH_MLEN:
                begin
                    left_next  = b;
                    index_next = 8'd0;
                    if (b == 8'd0)
                    begin
                        if (mtype_reg == META_EOT)
                        begin
                            ended_next = 1'b1;
                        end
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_META;
                        res_c.status_value = ST_META;
                        res_c.meta_type    = mtype_reg;
                    end
                    else
                    begin
                        phase_next = PH_MDATA;
                    end
                end
                PH_MDATA:
                begin
                    if (mtype_reg == META_TEMPO)
                    begin
                        if (index_reg == 8'd0)
                        begin
                            tempo_next = {b, 16'd0};
                        end
                        else if (index_reg == 8'd1)
                        begin
                            tempo_next = {tempo_reg[23:16], b, 8'd0};
                        end
                        else if (index_reg == 8'd2)
                        begin
                            tempo_next = {tempo_reg[23:8], b};
                        end
                    end
                    else if (mtype_reg == META_PREFIX && index_reg == 8'd0)
                    begin
                        prefix_next = b;
                    end
                    index_next = index_inc;
                    left_next  = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if (mtype_reg == META_EOT)
                        begin
                            ended_next = 1'b1;
                        end
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_META;
                        res_c.status_value = ST_META;
                        res_c.meta_type    = mtype_reg;
                        res_c.meta_size    = index_inc;
                    end
                end
                default:
                begin
                    // delta time: seven bits a byte, high bit marks more to come
                    acc_next = acc_shift;
                    if (!b[7])
                    begin
                        acc_next          = '0;
                        cnt_next          = '0;
                        phase_next        = PH_STATUS;
                        emit_c            = 1'b1;
                        res_c.kind        = KIND_DELTA;
                        res_c.delta_ticks = acc_shift;
                    end
                    else if (cnt_eff == CNT_LAST)
                    begin
                        acc_next           = '0;
                        cnt_next           = '0;
                        phase_next         = PH_DELTA;
                        emit_c             = 1'b1;
                        res_c.kind         = KIND_ERROR;
                        res_c.status_value = b;
                    end
                    else
                    begin
                        cnt_next   = cnt_eff + CNT_W'(1);
                        phase_next = PH_DELTA;
                    end
                end
            endcase
        end

        res_c.tempo_now      = tempo_next;
        res_c.prefix_channel = prefix_next;
        res_c.track_done     = ended_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            rs_reg     <= 8'd0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            first_reg  <= 8'd0;
            mtype_reg  <= 8'd0;
            left_reg   <= 8'd0;
            index_reg  <= 8'd0;
            tempo_reg  <= DEFAULT_TEMPO;
            prefix_reg <= 8'd0;
            ended_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            rs_reg     <= rs_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            mtype_reg  <= mtype_next;
            left_reg   <= left_next;
            index_reg  <= index_next;
            tempo_reg  <= tempo_next;
            prefix_reg <= prefix_next;
            ended_reg  <= ended_next;
        end
    end

    assign emit = emit_c;
    assign res  = res_c;

    // ended track stays silent until a restart
    a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ended_reg && !item.track_start |-> !emit_c)
        else $error("result produced after end of track");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_MDATA)
        else $error("phase register out of range");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("delta byte count past limit");

    a_eot_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit_c && res_c.kind == KIND_META && res_c.meta_type == META_EOT
        |=> ended_reg)
        else $error("end-of-track did not stop the parser");

    a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_DELTA |-> acc_reg == '0 && cnt_reg == '0)
        else $error("delta accumulator not clear outside delta phase");

endmodule

/* rtl/mtep_out_reg.sv */
// ----------------------------------------------------------------------------
// MIDI track parser output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              emit,
    input  mtep_pkg::result_t res_in,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              out_free,
    output mtep_pkg::result_t res
);
    import mtep_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_free = !vld_reg || m_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_free)
        begin
            vld_next = load && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit && out_free)
        begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = vld_reg;
    assign res      = res_reg;

endmodule

/* rtl/midi_track_event_parser_top.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses a standard MIDI file track body, one byte per transfer.
//
//   channel   dir  tdata                           tuser         tlast
//   s_axis    in   data_byte[7:0]                  track_start   -
//   m_axis    out  status..prefix_channel (104 b)  kind[2:0]     track_done
//
// One byte per cycle sustained while m_tready is high; each byte passes the
// input register, then parse logic into the output register.
// Each byte makes a single pass through the phase machine in mtep_core.
// Reset clears all parse state and sets tempo to 500000 us per quarter note.
// Back-pressure on m_axis stalls the parse stage, then s_tready.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
    parameter int MAX_DELTA_BYTES = mtep_pkg::DEFAULT_MAX_DELTA_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [mtep_pkg::DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] track_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] status_value, [14:8] first_data, [21:15] second_data,
    // [49:22] delta_ticks, [57:50] meta_type, [65:58] meta_size,
    // [89:66] tempo_now, [97:90] prefix_channel, [103:98] zero
    output logic [mtep_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [mtep_pkg::KIND_W-1:0]      m_tuser,   // [2:0] kind
    output logic         m_tlast    // track_done
);
    import mtep_pkg::*;

    in_item_t item_in;
    in_item_t item;
    logic     in_vld;
    logic     out_free;
    logic     fire;
    logic     emit;
    result_t  res_c;
    result_t  res;

    assign item_in.data_byte   = s_tdata;
    assign item_in.track_start = s_tuser;
    assign fire = in_vld && out_free;

    mtep_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_in  (item_in),
        .advance  (out_free),
        .vld      (in_vld),
        .item     (item)
    );

    mtep_core #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .emit  (emit),
        .res   (res_c)
    );

    mtep_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .emit     (emit),
        .res_in   (res_c),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_free (out_free),
        .res      (res)
    );

    assign m_tdata = {6'd0, res.prefix_channel, res.tempo_now, res.meta_size,
                      res.meta_type, res.delta_ticks, res.second_data,
                      res.first_data, res.status_value};
    assign m_tuser = res.kind;
    assign m_tlast = res.track_done;

endmodule
